FILE: sv/adc_rrss_pkg.sv
package adc_rrss_pkg;

	// channel storage and timestamp sizing
	localparam int MAX_CHANNELS = 4;
	localparam int TIME_BITS    = 32;
	localparam int NUM_MUX_REGS = 4;
	localparam int CHAN_BITS    = 2;
	localparam int ACTIVE_LIMIT = (MAX_CHANNELS < NUM_MUX_REGS) ? MAX_CHANNELS : NUM_MUX_REGS;

	// receive batch and sample constants
	localparam logic [3:0]  RX_BATCH_LEN = 4'd4;
	localparam int          OS_BIT       = 7;
	localparam logic [15:0] NORM_OFFSET  = 16'h8000;

	// event codes
	typedef enum logic [2:0] {
		REQ_ENABLE = 3'd0,
		REQ_READY  = 3'd1,
		REQ_POLL   = 3'd2,
		REQ_RECV   = 3'd3,
		REQ_READ   = 3'd4
	} req_type_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_NUM_CHANNELS = 3'd0,
		CFG_MUX_CHAN0    = 3'd1,
		CFG_MUX_CHAN1    = 3'd2,
		CFG_MUX_CHAN2    = 3'd3,
		CFG_MUX_CHAN3    = 3'd4,
		CFG_GAIN         = 3'd5,
		CFG_DATA_RATE    = 3'd6,
		CFG_READY_PIN    = 3'd7
	} cfg_reg_t;

	// converter config word: OS, mux, gain, single shot, rate
	function automatic logic [15:0] make_word(input logic [2:0] mux, input logic [2:0] gain,
			input logic [2:0] rate);
		make_word = {1'b1, mux, gain, 1'b1, rate, 5'b0};
	endfunction

endpackage

FILE: sv/adc_round_robin_scan_sequencer.sv
// each accepted input item gives a registered result item in the next cycle
// one item per cycle unless out_ready stalls; the single output register frees as taken
// all state is updated in the cycle an item is accepted, so items may follow back to back
// reset (arst_n low, asynchronous): scan idle, channel 0, nothing pending,
// stored samples and timestamps zero, config registers at their defaults
module adc_round_robin_scan_sequencer import adc_rrss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// config write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [2:0]         cfg_data,
	// event channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [7:0]         status_high,
	input  logic [7:0]         conv_high,
	input  logic [7:0]         conv_low,
	input  logic [3:0]         rx_length,
	input  logic [2:0]         read_channel,
	input  logic [31:0]        now_time,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               write_config,
	output logic [15:0]        config_word,
	output logic               issue_read,
	output logic               accepted,
	output logic signed [15:0] sample_native,
	output logic [15:0]        sample_norm,
	output logic [31:0]        sample_time,
	output logic               sample_valid
);

	// config registers
	logic [2:0] num_channels_q;
	logic [2:0] mux_chan_q [NUM_MUX_REGS];
	logic [2:0] gain_code_q;
	logic [2:0] data_rate_code_q;
	logic       ready_pin_present_q;

	// sequencer state
	logic                 scanning_q;
	logic [CHAN_BITS-1:0] scan_channel_q;
	logic                 config_pending_q;
	logic                 ready_seen_q;
	logic [15:0]          channel_samples_q [ACTIVE_LIMIT];
	logic [TIME_BITS-1:0] channel_times_q [ACTIVE_LIMIT];

	// result register
	logic        out_valid_q;
	logic        write_config_q;
	logic [15:0] config_word_q;
	logic        issue_read_q;
	logic        accepted_q;
	logic [15:0] sample_native_q;
	logic [15:0] sample_norm_q;
	logic [31:0] sample_time_q;
	logic        sample_valid_q;

	logic in_fire;
	logic [2:0] active_n;
	logic [CHAN_BITS-1:0] next_chan;
	logic rx_ok;
	logic rd_ok;
	logic [15:0] rd_sample;

	// next-cycle values
	logic                 scanning_d;
	logic [CHAN_BITS-1:0] scan_channel_d;
	logic                 config_pending_d;
	logic                 ready_seen_d;
	logic                 store_sample;
	logic                 write_config_d;
	logic [15:0]          config_word_d;
	logic                 issue_read_d;
	logic                 accepted_d;
	logic [15:0]          sample_native_d;
	logic [15:0]          sample_norm_d;
	logic [31:0]          sample_time_d;
	logic                 sample_valid_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	// clamp channel count to 1..limit
	always_comb begin
		if (num_channels_q == 3'd0)
			active_n = 3'd1;
		else if (num_channels_q > 3'(ACTIVE_LIMIT))
			active_n = 3'(ACTIVE_LIMIT);
		else
			active_n = num_channels_q;
	end

	// rotation step with wrap
	always_comb begin
		if ({1'b0, scan_channel_q} + 3'd1 >= active_n)
			next_chan = '0;
		else
			next_chan = scan_channel_q + CHAN_BITS'(1);
	end

	assign rx_ok = (rx_length == RX_BATCH_LEN) && scanning_q && status_high[OS_BIT];
	assign rd_ok = (read_channel < active_n);
	assign rd_sample = channel_samples_q[read_channel[CHAN_BITS-1:0]];

	// event decode
	always_comb begin
		scanning_d       = scanning_q;
		scan_channel_d   = scan_channel_q;
		config_pending_d = config_pending_q;
		ready_seen_d     = ready_seen_q;
		store_sample     = 1'b0;
		write_config_d   = 1'b0;
		config_word_d    = '0;
		issue_read_d     = 1'b0;
		accepted_d       = 1'b0;
		sample_native_d  = '0;
		sample_norm_d    = '0;
		sample_time_d    = '0;
		sample_valid_d   = 1'b0;
		unique case (req_type)
			REQ_ENABLE: begin
				if (!scanning_q) begin
					scanning_d       = 1'b1;
					scan_channel_d   = '0;
					config_pending_d = 1'b1;
				end
			end
			REQ_READY: begin
				ready_seen_d = 1'b1;
			end
			REQ_POLL: begin
				if (config_pending_q) begin
					write_config_d   = 1'b1;
					config_word_d    = make_word(mux_chan_q[scan_channel_q], gain_code_q,
						data_rate_code_q);
					config_pending_d = 1'b0;
				end
				if (!ready_pin_present_q || ready_seen_q) begin
					ready_seen_d = 1'b0;
					issue_read_d = 1'b1;
				end
			end
			REQ_RECV: begin
				if (rx_ok) begin
					store_sample   = 1'b1;
					scan_channel_d = next_chan;
					write_config_d = 1'b1;
					config_word_d  = make_word(mux_chan_q[next_chan], gain_code_q,
						data_rate_code_q);
					accepted_d     = 1'b1;
				end
			end
			REQ_READ: begin
				if (rd_ok) begin
					sample_native_d = rd_sample;
					sample_norm_d   = rd_sample ^ NORM_OFFSET;
					sample_time_d   = 32'(channel_times_q[read_channel[CHAN_BITS-1:0]]);
					sample_valid_d  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q      <= 3'd1;
			mux_chan_q[0]       <= 3'd4;
			mux_chan_q[1]       <= 3'd5;
			mux_chan_q[2]       <= 3'd6;
			mux_chan_q[3]       <= 3'd7;
			gain_code_q         <= 3'd1;
			data_rate_code_q    <= 3'd7;
			ready_pin_present_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NUM_CHANNELS: num_channels_q      <= cfg_data;
				CFG_MUX_CHAN0:    mux_chan_q[0]       <= cfg_data;
				CFG_MUX_CHAN1:    mux_chan_q[1]       <= cfg_data;
				CFG_MUX_CHAN2:    mux_chan_q[2]       <= cfg_data;
				CFG_MUX_CHAN3:    mux_chan_q[3]       <= cfg_data;
				CFG_GAIN:         gain_code_q         <= cfg_data;
				CFG_DATA_RATE:    data_rate_code_q    <= cfg_data;
				CFG_READY_PIN:    ready_pin_present_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q       <= 1'b0;
			scan_channel_q   <= '0;
			config_pending_q <= 1'b0;
			ready_seen_q     <= 1'b0;
		end else if (in_fire) begin
			scanning_q       <= scanning_d;
			scan_channel_q   <= scan_channel_d;
			config_pending_q <= config_pending_d;
			ready_seen_q     <= ready_seen_d;
		end
	end

	// sample and timestamp store, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACTIVE_LIMIT; i++) begin
				channel_samples_q[i] <= '0;
				channel_times_q[i]   <= '0;
			end
		end else if (in_fire && store_sample) begin
			channel_samples_q[scan_channel_q] <= {conv_high, conv_low};
			channel_times_q[scan_channel_q]   <= TIME_BITS'(now_time);
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_ready)
			out_valid_q <= in_valid;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			write_config_q  <= write_config_d;
			config_word_q   <= config_word_d;
			issue_read_q    <= issue_read_d;
			accepted_q      <= accepted_d;
			sample_native_q <= sample_native_d;
			sample_norm_q   <= sample_norm_d;
			sample_time_q   <= sample_time_d;
			sample_valid_q  <= sample_valid_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_config  = write_config_q;
	assign config_word   = config_word_q;
	assign issue_read    = issue_read_q;
	assign accepted      = accepted_q;
	assign sample_native = sample_native_q;
	assign sample_norm   = sample_norm_q;
	assign sample_time   = sample_time_q;
	assign sample_valid  = sample_valid_q;

`ifndef SYNTHESIS
	// config word only travels with a config write
	a_word_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !write_config_q |-> config_word_q == '0)
		else $error("config word set without write");

	// a stored sample always starts the next conversion
	a_accept_writes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && accepted_q |-> write_config_q && config_word_q[15])
		else $error("accepted sample without config write");

	// enable puts the sequencer in scanning state
	a_enable_scans: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_type == REQ_ENABLE |=> scanning_q)
		else $error("enable did not start scanning");

	// without a ready line every poll asks for a read
	a_poll_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_type == REQ_POLL && !ready_pin_present_q |=> issue_read_q)
		else $error("poll missed read request");

	// invalid read returns all zero fields
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !sample_valid_q |->
			sample_native_q == '0 && sample_norm_q == '0 && sample_time_q == '0)
		else $error("sample fields set on invalid read");

	// scan channel stays below the channel storage limit
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, scan_channel_q} < 3'(ACTIVE_LIMIT))
		else $error("scan channel out of range");
`endif

endmodule

FILE: dv/scan_checker.sv
`timescale 1ns / 100ps

module scan_checker import adc_rrss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// config write channel
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [2:0]         cfg_data,
	// event channel
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [7:0]         status_high,
	input  logic [7:0]         conv_high,
	input  logic [7:0]         conv_low,
	input  logic [3:0]         rx_length,
	input  logic [2:0]         read_channel,
	input  logic [31:0]        now_time,
	// result channel
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               write_config,
	input  logic [15:0]        config_word,
	input  logic               issue_read,
	input  logic               accepted,
	input  logic signed [15:0] sample_native,
	input  logic [15:0]        sample_norm,
	input  logic [31:0]        sample_time,
	input  logic               sample_valid,
	// to the top
	output int                 fail_total,
	output int                 results_owed
);

	typedef struct packed {
		logic               write_config;
		logic [15:0]        config_word;
		logic               issue_read;
		logic               accepted;
		logic signed [15:0] sample_native;
		logic [15:0]        sample_norm;
		logic [31:0]        sample_time;
		logic               sample_valid;
	} scan_result_t;

	// expected result items, oldest first
	scan_result_t owed_q[$];

	// shadow copy of the config registers
	logic [2:0] num_ch_reg;
	logic [2:0] mux_reg [NUM_MUX_REGS];
	logic [2:0] gain_reg;
	logic [2:0] rate_reg;
	logic       rdy_pin_reg;

	// shadow copy of the sequencer state
	logic                 scan_on;
	logic [CHAN_BITS-1:0] scan_ch;
	logic                 word_owed;
	logic                 rdy_edge;
	logic [15:0]          smp [MAX_CHANNELS];
	logic [31:0]          stamp [MAX_CHANNELS];

	int fails = 0;
	int reported = 0;

	// channels in the rotation after clamping
	function automatic int chan_count();
		int n;
		n = int'(num_ch_reg);
		if (n == 0)
			n = 1;
		if (n > ACTIVE_LIMIT)
			n = ACTIVE_LIMIT;
		return n;
	endfunction

	// config word that starts a conversion on a logical channel
	function automatic logic [15:0] start_word(input logic [CHAN_BITS-1:0] chan);
		logic [15:0] w;
		w = 16'h8000 | 16'h0100;
		w[14:12] = mux_reg[chan];
		w[11:9] = gain_reg;
		w[7:5] = rate_reg;
		return w;
	endfunction

	// advance the shadow state by one event, return its result item
	function automatic scan_result_t apply_event();
		scan_result_t r;
		int nxt;
		r = '0;
		case (req_type)
			REQ_ENABLE: begin
				if (!scan_on) begin
					scan_on = 1'b1;
					scan_ch = '0;
					word_owed = 1'b1;
				end
			end
			REQ_READY: rdy_edge = 1'b1;
			REQ_POLL: begin
				if (word_owed) begin
					r.write_config = 1'b1;
					r.config_word = start_word(scan_ch);
					word_owed = 1'b0;
				end
				if (!rdy_pin_reg || rdy_edge) begin
					rdy_edge = 1'b0;
					r.issue_read = 1'b1;
				end
			end
			REQ_RECV: begin
				if (rx_length == RX_BATCH_LEN && scan_on && status_high[OS_BIT]) begin
					smp[scan_ch] = {conv_high, conv_low};
					stamp[scan_ch] = now_time;
					nxt = scan_ch + 1;
					if (nxt >= chan_count())
						nxt = 0;
					scan_ch = nxt[CHAN_BITS-1:0];
					r.write_config = 1'b1;
					r.config_word = start_word(scan_ch);
					r.accepted = 1'b1;
				end
			end
			REQ_READ: begin
				if (read_channel < chan_count() && read_channel < MAX_CHANNELS) begin
					r.sample_native = smp[read_channel[CHAN_BITS-1:0]];
					r.sample_norm = smp[read_channel[CHAN_BITS-1:0]] + NORM_OFFSET;
					r.sample_time = stamp[read_channel[CHAN_BITS-1:0]];
					r.sample_valid = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// config register write seen on the bus
	function automatic void store_reg();
		case (cfg_index)
			CFG_NUM_CHANNELS: num_ch_reg = cfg_data;
			CFG_MUX_CHAN0:    mux_reg[0] = cfg_data;
			CFG_MUX_CHAN1:    mux_reg[1] = cfg_data;
			CFG_MUX_CHAN2:    mux_reg[2] = cfg_data;
			CFG_MUX_CHAN3:    mux_reg[3] = cfg_data;
			CFG_GAIN:         gain_reg = cfg_data;
			CFG_DATA_RATE:    rate_reg = cfg_data;
			CFG_READY_PIN:    rdy_pin_reg = cfg_data[0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			fails++;
			if (reported < 10) begin
				reported++;
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, seen);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_result_t got;
		scan_result_t want;
		if (!arst_n) begin
			owed_q.delete();
			num_ch_reg = 3'd1;
			mux_reg[0] = 3'd4;
			mux_reg[1] = 3'd5;
			mux_reg[2] = 3'd6;
			mux_reg[3] = 3'd7;
			gain_reg = 3'd1;
			rate_reg = 3'd7;
			rdy_pin_reg = 1'b0;
			scan_on = 1'b0;
			scan_ch = '0;
			word_owed = 1'b0;
			rdy_edge = 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				smp[i] = '0;
				stamp[i] = '0;
			end
		end else begin
			// result side: match against the oldest expectation
			if (out_valid && out_ready) begin
				got = '{write_config, config_word, issue_read, accepted, sample_native,
					sample_norm, sample_time, sample_valid};
				if (owed_q.size() == 0) begin
					fails++;
					if (reported < 10) begin
						reported++;
						$display("%0t: result item with none expected: %h", $realtime, got);
					end
				end else begin
					want = owed_q.pop_front();
					check_field("write_config", 32'(want.write_config), 32'(got.write_config));
					check_field("config_word", 32'(want.config_word), 32'(got.config_word));
					check_field("issue_read", 32'(want.issue_read), 32'(got.issue_read));
					check_field("accepted", 32'(want.accepted), 32'(got.accepted));
					check_field("sample_native", 32'(want.sample_native),
						32'(got.sample_native));
					check_field("sample_norm", 32'(want.sample_norm), 32'(got.sample_norm));
					check_field("sample_time", want.sample_time, got.sample_time);
					check_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
				end
			end
			// event side
			if (in_valid && in_ready)
				owed_q.push_back(apply_event());
			// config side
			if (cfg_valid && cfg_ready)
				store_reg();
		end
		results_owed <= owed_q.size();
		fail_total <= fails;
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import adc_rrss_pkg::*;

	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int RANDOM_PER_PHASE = 270;
	localparam int SETTLE_CYCLES    = 4;

	typedef struct {
		logic [2:0]  req;
		logic [7:0]  status;
		logic [7:0]  chi;
		logic [7:0]  clo;
		logic [3:0]  len;
		logic [2:0]  rch;
		logic [31:0] now;
	} scan_event_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [2:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         req_type = '0;
	logic [7:0]         status_high = '0;
	logic [7:0]         conv_high = '0;
	logic [7:0]         conv_low = '0;
	logic [3:0]         rx_length = '0;
	logic [2:0]         read_channel = '0;
	logic [31:0]        now_time = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               write_config;
	logic [15:0]        config_word;
	logic               issue_read;
	logic               accepted;
	logic signed [15:0] sample_native;
	logic [15:0]        sample_norm;
	logic [31:0]        sample_time;
	logic               sample_valid;

	int fail_total;
	int results_owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	adc_round_robin_scan_sequencer dut (.*);

	scan_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls at the phase rate
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic scan_event_t ev_of(input logic [2:0] req, input logic [7:0] status,
			input logic [7:0] chi, input logic [7:0] clo, input logic [3:0] len,
			input logic [2:0] rch, input logic [31:0] now);
		scan_event_t ev;
		ev = '{req, status, chi, clo, len, rch, now};
		return ev;
	endfunction

	// present one item, valid stays high until it is taken
	task automatic send_event(input scan_event_t ev);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= ev.req;
		status_high <= ev.status;
		conv_high <= ev.chi;
		conv_low <= ev.clo;
		rx_length <= ev.len;
		read_channel <= ev.rch;
		now_time <= ev.now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop sending and wait for every owed result item
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// valid is left high so back to back writes need no dip
	task automatic write_reg(input cfg_reg_t idx, input logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(input logic [2:0] num, input logic [2:0] m0,
			input logic [2:0] m1, input logic [2:0] m2, input logic [2:0] m3,
			input logic [2:0] gain, input logic [2:0] rate, input logic rdy);
		write_reg(CFG_NUM_CHANNELS, num);
		write_reg(CFG_MUX_CHAN0, m0);
		write_reg(CFG_MUX_CHAN1, m1);
		write_reg(CFG_MUX_CHAN2, m2);
		write_reg(CFG_MUX_CHAN3, m3);
		write_reg(CFG_GAIN, gain);
		write_reg(CFG_DATA_RATE, rate);
		write_reg(CFG_READY_PIN, {2'b0, rdy});
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed scan traffic with some noise
	function automatic scan_event_t random_event(output bit counts);
		scan_event_t ev;
		int pick;
		ev = ev_of(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), $urandom);
		pick = $urandom_range(0, 99);
		counts = 1'b1;
		if (pick < 4)
			ev.req = REQ_ENABLE;
		else if (pick < 18)
			ev.req = REQ_READY;
		else if (pick < 43)
			ev.req = REQ_POLL;
		else if (pick < 73) begin
			ev.req = REQ_RECV;
			if ($urandom_range(0, 3) != 0) begin
				ev.len = RX_BATCH_LEN;
				ev.status[OS_BIT] = 1'b1;
			end
			counts = (ev.len == RX_BATCH_LEN) && ev.status[OS_BIT];
		end else if (pick < 95) begin
			ev.req = REQ_READ;
			if ($urandom_range(0, 4) != 0)
				ev.rch = 3'($urandom_range(0, MAX_CHANNELS - 1));
		end else begin
			ev.req = 3'($urandom_range(REQ_READ + 1, 7));
			counts = 1'b0;
		end
		return ev;
	endfunction

	initial begin
		scan_event_t ev;
		bit counts;
		int done;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset config: idle scanner, odd codes, first samples
		send_event(ev_of(REQ_RECV, 8'h80, 8'h12, 8'h34, 4'd4, 3'd0, 32'h1));
		send_event(ev_of(REQ_READ, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_READ, 8'h00, 8'h00, 8'h00, 4'd0, 3'd7, 32'h0));
		for (int u = REQ_READ + 1; u < 8; u++)
			send_event(ev_of(3'(u), 8'hff, 8'hff, 8'hff, 4'd4, 3'd0, 32'hffff_ffff));
		send_event(ev_of(REQ_READY, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_POLL, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_ENABLE, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_ENABLE, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_POLL, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_RECV, 8'h80, 8'h55, 8'haa, 4'd3, 3'd0, 32'h5));
		send_event(ev_of(REQ_RECV, 8'h7f, 8'h55, 8'haa, 4'd4, 3'd0, 32'h6));
		send_event(ev_of(REQ_RECV, 8'h80, 8'h80, 8'h00, 4'd4, 3'd0, 32'hffff_ffff));
		send_event(ev_of(REQ_READ, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_READ, 8'h00, 8'h00, 8'h00, 4'd0, 3'd1, 32'h0));
		send_event(ev_of(REQ_RECV, 8'h80, 8'h7f, 8'hff, 4'd4, 3'd0, 32'h0));
		send_event(ev_of(REQ_READ, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));

		// directed, four channels with a ready line fitted
		drain();
		program_regs(3'd4, 3'd0, 3'd7, 3'd0, 3'd7, 3'd5, 3'd0, 1'b1);
		send_event(ev_of(REQ_POLL, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_READY, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_POLL, 8'h00, 8'h00, 8'h00, 4'd0, 3'd0, 32'h0));
		send_event(ev_of(REQ_RECV, 8'hff, 8'hff, 8'hff, 4'd4, 3'd0, 32'h8000_0000));
		send_event(ev_of(REQ_RECV, 8'h80, 8'h00, 8'h00, 4'd4, 3'd0, 32'h0000_0001));
		for (int c = 0; c < MAX_CHANNELS; c++)
			send_event(ev_of(REQ_READ, 8'h00, 8'h00, 8'h00, 4'd0, 3'(c), 32'h0));

		// random phases, each with its own config and its own mix of idle and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					program_regs(3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd0, 3'd0, 1'b0);
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					program_regs(3'd2, 3'd7, 3'd0, 3'd1, 3'd2, 3'd7, 3'd7, 1'b1);
					idle_pct = 66;
					stall_pct = 0;
				end
				2: begin
					program_regs(3'd0, 3'd2, 3'd6, 3'd4, 3'd1, 3'd5, 3'd3, 1'b0);
					idle_pct = 0;
					stall_pct = 66;
				end
				default: begin
					program_regs(3'd7, 3'd5, 3'd3, 3'd7, 3'd0, 3'd2, 3'd5, 1'b1);
					idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			done = 0;
			while (done < RANDOM_PER_PHASE) begin
				ev = random_event(counts);
				send_event(ev);
				if (counts)
					done++;
				// hold off mid-phase until the result queue is empty
				if (done == RANDOM_PER_PHASE / 2 && counts)
					drain();
			end
		end

		drain();
		if (fail_total == 0 && results_owed == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
